>>> design/omf_pkg.sv
// Shared types and constants for the output mismatch fault monitor.
// No dependencies; the interfaces and the top level use it by scoped names.
`timescale 1ns / 1ps

package omf_pkg;

  localparam int STATE_W   = 8;
  localparam int COUNT_W   = 16;
  localparam int TIME_W    = 32;
  localparam int TOTAL_W   = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam int THR_W     = 28;

  localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;
  localparam logic [11:0]        SECONDS_PER_HOUR = 12'd3600;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT          = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_LIMIT          = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD_COUNT_LIMIT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD_HOURS_LIMIT = 8'd3;

  localparam logic [COUNT_W-1:0] ERROR_LIMIT_RST          = 16'd10;
  localparam logic [COUNT_W-1:0] VALID_LIMIT_RST          = 16'd10;
  localparam logic [TOTAL_W-1:0] OVERLOAD_COUNT_LIMIT_RST = 8'd3;
  // Reset hours limit of 24, kept as seconds.
  localparam logic [THR_W-1:0]   OVERLOAD_THR_RST         = 28'd86400;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_MEASURE = 1'b1;

  typedef struct packed {
    logic fault_active;
    logic fault_raised;
    logic fault_cleared;
    logic overload_raised;
  } result_t;

  // Residue modulo 3 of a byte by folding base-4 digits, since 4 is 1 mod 3.
  function automatic logic [1:0] mod3_u8(input logic [7:0] x);
    logic [3:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = 4'(x[7:6]) + 4'(x[5:4]) + 4'(x[3:2]) + 4'(x[1:0]);
    s2 = 3'(s1[3:2]) + 3'(s1[1:0]);
    s3 = 3'(s2[2]) + 3'(s2[1:0]);
    mod3_u8 = (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
  endfunction

endpackage

>>> design/omf_if.sv
// Valid/ready channel interfaces for the monitor's input and result items.
// Depends on omf_pkg for the field widths.
`timescale 1ns / 1ps

interface omf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [omf_pkg::STATE_W-1:0]   state_value;
  logic [omf_pkg::TIME_W-1:0]    occurrence_time;
  logic [omf_pkg::TOTAL_W-1:0]   occurrence_total;

  modport source (output valid, kind, state_value, occurrence_time, occurrence_total,
                  input ready);
  modport sink   (input valid, kind, state_value, occurrence_time, occurrence_total,
                  output ready);
endinterface

interface omf_out_if;
  logic valid;
  logic ready;
  logic fault_active;
  logic fault_raised;
  logic fault_cleared;
  logic overload_raised;

  modport source (output valid, fault_active, fault_raised, fault_cleared, overload_raised,
                  input ready);
  modport sink   (input valid, fault_active, fault_raised, fault_cleared, overload_raised,
                  output ready);
endinterface

>>> design/output_mismatch_fault_monitor_top.sv
// Output mismatch fault monitor: input register, state update, result buffer.
// Depends on omf_pkg and the channel interfaces in omf_if.sv.
// An accepted item is held in the input register; its result is registered into the result buffer and offered.
// Throughput: one item per cycle while the skid entry is empty; counter and ring update are combinational.
// A two-entry result buffer keeps input flowing while a result waits.
// Reset (synchronous, rst_n low) restores counters, fault flag, time ring and limits.
`timescale 1ns / 1ps

module output_mismatch_fault_monitor_top (
  input  logic                             clk,
  input  logic                             rst_n,
  omf_in_if.sink                           in_ch,
  omf_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [omf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [omf_pkg::CFG_DAT_W-1:0]    cfg_data
);

  localparam int GAP_W = omf_pkg::TIME_W + 1;

  // Configuration.
  logic [omf_pkg::COUNT_W-1:0] error_limit_r, valid_limit_r;
  logic [omf_pkg::TOTAL_W-1:0] ovl_count_limit_r;
  logic [omf_pkg::THR_W-1:0]   ovl_thr_r;

  // Input stage.
  logic                        s1_valid_r;
  logic                        s1_kind_r;
  logic [omf_pkg::STATE_W-1:0] s1_value_r;
  logic [omf_pkg::TIME_W-1:0]  s1_time_r;
  logic [omf_pkg::TOTAL_W-1:0] s1_total_r;

  // Monitor state.
  logic [omf_pkg::STATE_W-1:0] req_state_r, req_state_nxt;
  logic [omf_pkg::COUNT_W-1:0] mismatch_cnt_r, mismatch_cnt_nxt;
  logic [omf_pkg::COUNT_W-1:0] match_cnt_r, match_cnt_nxt;
  logic                        fault_flag_r, fault_flag_nxt;
  logic [omf_pkg::TIME_W-1:0]  ring_r [3];
  logic [omf_pkg::TIME_W-1:0]  ring_nxt [3];

  // Result buffer.
  logic             out_valid_r, skid_valid_r;
  omf_pkg::result_t out_data_r, skid_data_r, res_nxt;

  logic in_ready, in_acc, s1_adv, pop;
  logic [omf_pkg::COUNT_W-1:0] mm_inc, mc_inc;
  logic [1:0] slot;
  logic [GAP_W-1:0] thr_ext;
  logic all_close;

  assign in_ready    = !s1_valid_r || !skid_valid_r;
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign s1_adv      = s1_valid_r && !skid_valid_r;
  assign pop         = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_limit_r     <= omf_pkg::ERROR_LIMIT_RST;
      valid_limit_r     <= omf_pkg::VALID_LIMIT_RST;
      ovl_count_limit_r <= omf_pkg::OVERLOAD_COUNT_LIMIT_RST;
      ovl_thr_r         <= omf_pkg::OVERLOAD_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        omf_pkg::CFG_ERROR_LIMIT:          error_limit_r <= cfg_data;
        omf_pkg::CFG_VALID_LIMIT:          valid_limit_r <= cfg_data;
        omf_pkg::CFG_OVERLOAD_COUNT_LIMIT: ovl_count_limit_r <= cfg_data[omf_pkg::TOTAL_W-1:0];
        // Hours are kept as seconds: floor(gap / 3600) < h exactly when gap < h * 3600.
        omf_pkg::CFG_OVERLOAD_HOURS_LIMIT: begin
          ovl_thr_r <= omf_pkg::THR_W'(cfg_data) * omf_pkg::THR_W'(omf_pkg::SECONDS_PER_HOUR);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc || (s1_valid_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= in_ch.kind;
      s1_value_r <= in_ch.state_value;
      s1_time_r  <= in_ch.occurrence_time;
      s1_total_r <= in_ch.occurrence_total;
    end
  end

  // True when the two times are less than the threshold apart.
  function automatic logic gap_ok(input logic [omf_pkg::TIME_W-1:0] a,
                                  input logic [omf_pkg::TIME_W-1:0] b,
                                  input logic [GAP_W-1:0] thr);
    logic [GAP_W-1:0] ae, be;
    ae = GAP_W'(a);
    be = GAP_W'(b);
    gap_ok = (ae < be + thr) && (be < ae + thr);
  endfunction

  assign thr_ext = GAP_W'(ovl_thr_r);
  assign mm_inc  = (mismatch_cnt_r == omf_pkg::COUNT_MAX) ? mismatch_cnt_r
                                                           : mismatch_cnt_r + 16'd1;
  assign mc_inc  = (match_cnt_r == omf_pkg::COUNT_MAX) ? match_cnt_r : match_cnt_r + 16'd1;
  assign slot    = omf_pkg::mod3_u8(s1_total_r - 8'd1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ring_nxt[i] = (slot == 2'(i)) ? s1_time_r : ring_r[i];
    end
    all_close = gap_ok(ring_nxt[0], ring_nxt[1], thr_ext) &&
                gap_ok(ring_nxt[0], ring_nxt[2], thr_ext) &&
                gap_ok(ring_nxt[1], ring_nxt[2], thr_ext);
  end

  always_comb begin
    req_state_nxt    = req_state_r;
    mismatch_cnt_nxt = mismatch_cnt_r;
    match_cnt_nxt    = match_cnt_r;
    fault_flag_nxt   = fault_flag_r;
    res_nxt          = '0;
    if (s1_kind_r == omf_pkg::KIND_REQUEST) begin
      req_state_nxt = s1_value_r;
    end else if (s1_value_r == req_state_r) begin
      mismatch_cnt_nxt = '0;
      match_cnt_nxt    = mc_inc;
      if (fault_flag_r && (mc_inc >= valid_limit_r)) begin
        fault_flag_nxt        = 1'b0;
        match_cnt_nxt         = '0;
        res_nxt.fault_cleared = 1'b1;
      end
    end else begin
      match_cnt_nxt    = '0;
      mismatch_cnt_nxt = mm_inc;
      if (mm_inc >= error_limit_r) begin
        fault_flag_nxt          = 1'b1;
        mismatch_cnt_nxt        = '0;
        res_nxt.fault_raised    = 1'b1;
        res_nxt.overload_raised = (s1_total_r >= ovl_count_limit_r) && all_close;
      end
    end
    res_nxt.fault_active = fault_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_state_r    <= '0;
      mismatch_cnt_r <= '0;
      match_cnt_r    <= '0;
      fault_flag_r   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ring_r[i] <= '0;
      end
    end else if (s1_adv) begin
      req_state_r    <= req_state_nxt;
      mismatch_cnt_r <= mismatch_cnt_nxt;
      match_cnt_r    <= match_cnt_nxt;
      fault_flag_r   <= fault_flag_nxt;
      // The ring only takes the new time when a fault is reported.
      if (res_nxt.fault_raised) begin
        for (int i = 0; i < 3; i++) begin
          ring_r[i] <= ring_nxt[i];
        end
      end
    end
  end

  // Result buffer: a push only happens while the skid entry is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (s1_adv) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (s1_adv) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= res_nxt;
      end else begin
        out_data_r <= res_nxt;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.fault_active    = out_data_r.fault_active;
  assign out_ch.fault_raised    = out_data_r.fault_raised;
  assign out_ch.fault_cleared   = out_data_r.fault_cleared;
  assign out_ch.overload_raised = out_data_r.overload_raised;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_counts_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (mismatch_cnt_r == '0) || (match_cnt_r == '0))
    else $error("mismatch and match counts are both nonzero");

  a_raise_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res_nxt.fault_raised) |=> fault_flag_r)
    else $error("fault flag not set after a fault report");

  a_clear_drops_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res_nxt.fault_cleared) |=> (!fault_flag_r && (match_cnt_r == '0)))
    else $error("fault flag or match count not cleared after a fault clear");

  a_overload_needs_raise: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.overload_raised || out_data_r.fault_raised))
    else $error("overload reported without a fault report");

endmodule
